FILE: rtl/core/binary_min_heap_queue_top_macros.svh
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// A condition that must hold at every clock edge outside reset.
`define BMHQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after the trigger.
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define BMHQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define BMHQ_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif

`endif

FILE: rtl/core/bmhq_pkg.sv
// Types and constants of the binary min-heap queue.
`default_nettype none

package bmhq_pkg;

    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_EXTRACT = 2'd1,
        REQ_DELETE  = 2'd2,
        REQ_IGNORE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_req               req_type;
        logic signed [31:0] key_value;
        logic [5:0]         entry_index;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_key;
        t_status            status;
        logic [6:0]         occupancy;
    } t_out_word;

endpackage

`default_nettype wire

FILE: rtl/core/bmhq_ram.sv
// Heap key store: one write port and one read port with registered read data.
`default_nettype none

module bmhq_ram #(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic signed [31:0]                o_rd_data,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire logic signed [31:0]           i_wr_data
);

    logic signed [31:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/binary_min_heap_queue_top.sv
// Binary min-heap priority queue of signed keys held in a single-port-read RAM.
//
//   channel  | handshake                 | word
//   ---------+---------------------------+-----------------------------------
//   request  | i_in_valid / o_in_ready   | i_in_word  (type, key, index)
//   result   | o_out_valid / i_out_ready | o_out_word (key, status, count)
//   config   | i_cfg_wr_en               | i_cfg_wr_data (capacity limit)
//
// One request at a time; a key climbs a level by reading its parent (S_UP_RD) and then
// comparing and writing (S_UP_CMP), and sinks a level by reading the left child, reading the
// right child and comparing (S_DN_RDL, S_DN_RDR, S_DN_CMP), over up to 6 levels. Errors and
// ignored requests go straight to done; a delete first shifts the index's ancestors down.
// Reset is synchronous and empties the heap at once; RAM contents are not cleared.
// A finished word waits in the output register while the next request is taken, and the
// next word holds in the done state until that one is accepted.
`default_nettype none

`include "binary_min_heap_queue_top_macros.svh"

module binary_min_heap_queue_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire bmhq_pkg::t_in_word         i_in_word,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output bmhq_pkg::t_out_word             o_out_word,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [bmhq_pkg::CAP_W-1:0] i_cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W;

    bmhq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [bmhq_pkg::CAP_W-1:0] r_cap;
    logic [AW-1:0]       r_idx, n_idx;
    logic signed [31:0]  r_key, n_key;
    logic signed [31:0]  r_ldata, n_ldata;
    logic                r_rvalid, n_rvalid;
    logic signed [31:0]  r_res, n_res;
    bmhq_pkg::t_status   r_status, n_status;
    logic                r_extract, n_extract;
    logic                r_out_valid, n_out_valid;
    bmhq_pkg::t_out_word r_out, n_out;

    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic signed [31:0]  w_rd_data;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic signed [31:0]  w_wr_data;

    logic                w_acc;
    logic                w_full;
    logic [XW-1:0]       w_cnt_x;
    logic [AW-1:0]       w_parent;
    logic [AW+1:0]       w_lchild;
    logic [AW+1:0]       w_rchild;
    logic [AW+1:0]       w_cnt_c;
    logic                w_l_in;
    logic                w_r_in;
    logic signed [31:0]  w_min;
    logic [AW-1:0]       w_sel;
    logic                w_move;
    logic                w_ins;
    logic [CW-1:0]       w_cnt_inc;
    logic                w_wr_live;

    bmhq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    assign o_in_ready  = (r_state == bmhq_pkg::S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_cnt_x  = XW'(r_count);
    // The capacity in effect never exceeds the store depth.
    assign w_full   = (w_cnt_x >= XW'(r_cap)) || (w_cnt_x == XW'(DEPTH));
    assign w_parent = (r_idx - AW'(1)) >> 1;
    assign w_lchild = {1'b0, r_idx, 1'b1};
    assign w_rchild = {1'b0, r_idx, 1'b0} + (AW+2)'(2);
    assign w_cnt_c  = (AW+2)'(r_count);
    assign w_l_in   = (w_lchild < w_cnt_c);
    assign w_r_in   = (w_rchild < w_cnt_c);

    assign w_ins     = w_acc && (i_in_word.req_type == bmhq_pkg::REQ_INSERT) && !w_full;
    assign w_cnt_inc = r_count + CW'(1);
    assign w_wr_live = !w_wr_en || ((AW+2)'(w_wr_addr) < w_cnt_c);

    // Smaller of the moving key and its children; the right child must be strictly
    // smaller than the winner of the first compare to take the slot.
    always_comb begin
        w_min  = r_key;
        w_sel  = r_idx;
        w_move = 1'b0;
        if (r_ldata < w_min) begin
            w_min  = r_ldata;
            w_sel  = w_lchild[AW-1:0];
            w_move = 1'b1;
        end
        if (r_rvalid && (w_rd_data < w_min)) begin
            w_min  = w_rd_data;
            w_sel  = w_rchild[AW-1:0];
            w_move = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_key       = r_key;
        n_ldata     = r_ldata;
        n_rvalid    = r_rvalid;
        n_res       = r_res;
        n_status    = r_status;
        n_extract   = r_extract;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        w_wr_en     = 1'b0;
        w_wr_addr   = '0;
        w_wr_data   = r_key;

        unique case (r_state)
            bmhq_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_res     = '0;
                    n_status  = bmhq_pkg::ST_OK;
                    n_extract = 1'b0;
                    unique case (i_in_word.req_type)
                        bmhq_pkg::REQ_INSERT: begin
                            if (w_full) begin
                                n_status = bmhq_pkg::ST_FULL;
                                n_state  = bmhq_pkg::S_DONE;
                            end else begin
                                n_key   = i_in_word.key_value;
                                n_idx   = r_count[AW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = bmhq_pkg::S_UP_RD;
                            end
                        end
                        bmhq_pkg::REQ_EXTRACT: begin
                            if (r_count == '0) begin
                                n_res    = bmhq_pkg::INT_MAX;
                                n_status = bmhq_pkg::ST_EMPTY;
                                n_state  = bmhq_pkg::S_DONE;
                            end else begin
                                n_extract = 1'b1;
                                n_state   = bmhq_pkg::S_POP_RD0;
                            end
                        end
                        bmhq_pkg::REQ_DELETE: begin
                            if (XW'(i_in_word.entry_index) >= w_cnt_x) begin
                                n_status = bmhq_pkg::ST_RANGE;
                                n_state  = bmhq_pkg::S_DONE;
                            end else begin
                                n_idx   = AW'(i_in_word.entry_index);
                                n_state = bmhq_pkg::S_DEL_RD;
                            end
                        end
                        default: begin
                            n_state = bmhq_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bmhq_pkg::S_UP_RD: begin
                if (r_idx == '0) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx;
                    n_state   = bmhq_pkg::S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_parent;
                    n_state   = bmhq_pkg::S_UP_CMP;
                end
            end
            bmhq_pkg::S_UP_CMP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                if (r_key < w_rd_data) begin
                    // The parent drops into the hole and the hole moves up.
                    w_wr_data = w_rd_data;
                    n_idx     = w_parent;
                    n_state   = bmhq_pkg::S_UP_RD;
                end else begin
                    n_state = bmhq_pkg::S_DONE;
                end
            end
            bmhq_pkg::S_DEL_RD: begin
                if (r_idx == '0) begin
                    n_state = bmhq_pkg::S_POP_RD0;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_parent;
                    n_state   = bmhq_pkg::S_DEL_WR;
                end
            end
            bmhq_pkg::S_DEL_WR: begin
                // Shifting each ancestor down one level overwrites the chosen entry, and the
                // pop then discards the root, whose key now also sits in its child.
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_rd_data;
                n_idx     = w_parent;
                n_state   = bmhq_pkg::S_DEL_RD;
            end
            bmhq_pkg::S_POP_RD0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
                n_count   = r_count - CW'(1);
                n_state   = bmhq_pkg::S_POP_RDL;
            end
            bmhq_pkg::S_POP_RDL: begin
                if (r_extract) begin
                    n_res = w_rd_data;
                end
                if (r_count == '0) begin
                    n_state = bmhq_pkg::S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_count[AW-1:0];
                    n_state   = bmhq_pkg::S_POP_LAST;
                end
            end
            bmhq_pkg::S_POP_LAST: begin
                n_key   = w_rd_data;
                n_idx   = '0;
                n_state = bmhq_pkg::S_DN_RDL;
            end
            bmhq_pkg::S_DN_RDL: begin
                if (!w_l_in) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_idx;
                    n_state   = bmhq_pkg::S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_lchild[AW-1:0];
                    n_state   = bmhq_pkg::S_DN_RDR;
                end
            end
            bmhq_pkg::S_DN_RDR: begin
                n_ldata  = w_rd_data;
                n_rvalid = w_r_in;
                if (w_r_in) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rchild[AW-1:0];
                end
                n_state = bmhq_pkg::S_DN_CMP;
            end
            bmhq_pkg::S_DN_CMP: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                if (w_move) begin
                    w_wr_data = w_min;
                    n_idx     = w_sel;
                    n_state   = bmhq_pkg::S_DN_RDL;
                end else begin
                    n_state = bmhq_pkg::S_DONE;
                end
            end
            bmhq_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_out.result_key = r_res;
                    n_out.status     = r_status;
                    n_out.occupancy  = w_cnt_x[bmhq_pkg::CAP_W-1:0];
                    n_state          = bmhq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhq_pkg::S_IDLE;
            r_count     <= '0;
            r_cap       <= bmhq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_key     <= n_key;
        r_ldata   <= n_ldata;
        r_rvalid  <= n_rvalid;
        r_res     <= n_res;
        r_status  <= n_status;
        r_extract <= n_extract;
        r_out     <= n_out;
    end

    `BMHQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, w_cnt_x <= XW'(DEPTH), "count above depth")
    `BMHQ_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, w_ins, r_count == $past(w_cnt_inc), "insert lost")
    `BMHQ_ASSERT_ALWAYS(a_write_in_heap, i_clk, i_rst_n, w_wr_live, "write beyond live entries")

endmodule

`default_nettype wire

FILE: tb/sv/tb_binary_min_heap_queue_top.sv
// Self-checking bench for the min-heap queue: directed, capacity, full-heap and random traffic.
module tb_binary_min_heap_queue_top;
    import bmhq_pkg::*;

    localparam int DEPTH         = 64;
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOW_LIMIT    = 10;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                in_valid      = 1'b0;
    t_in_word            in_word       = '0;
    logic                out_ready     = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data   = CAP_RESET;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_word           o_out_word;

    // Shadow copy of the heap, its fill count and the capacity register.
    logic signed [31:0]  heap_keys [DEPTH];
    int                  heap_fill = 0;
    logic [CAP_W-1:0]    heap_cap  = CAP_RESET;

    t_out_word           pending_words[$];
    t_out_word           oldest_word;
    int                  mismatch_count = 0;
    int                  cycle_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    binary_min_heap_queue_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (in_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_out_word   (o_out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** binary_min_heap_queue_top: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Removes the root of the shadow heap and restores order from the top down.
    function automatic logic signed [31:0] pop_min_key();
        logic signed [31:0] root;
        logic signed [31:0] tmp;
        int                 i;
        int                 l;
        int                 r;
        int                 s;
        bit                 settled;
        root = heap_keys[0];
        heap_fill--;
        if (heap_fill > 0) begin
            heap_keys[0] = heap_keys[heap_fill];
            i = 0;
            settled = 1'b0;
            while (!settled) begin
                l = 2 * i + 1;
                r = 2 * i + 2;
                s = i;
                if (l < heap_fill && heap_keys[l] < heap_keys[s]) s = l;
                if (r < heap_fill && heap_keys[r] < heap_keys[s]) s = r;
                if (s == i) begin
                    settled = 1'b1;
                end else begin
                    tmp = heap_keys[s];
                    heap_keys[s] = heap_keys[i];
                    heap_keys[i] = tmp;
                    i = s;
                end
            end
        end
        return root;
    endfunction

    function automatic t_out_word predict_heap_result(t_in_word w);
        t_out_word          r;
        logic signed [31:0] tmp;
        int                 i;
        int                 p;
        int                 eff_cap;
        r.result_key = '0;
        r.status = ST_OK;
        eff_cap = (heap_cap > DEPTH) ? DEPTH : int'(heap_cap);
        case (w.req_type)
            REQ_INSERT: begin
                if (heap_fill >= eff_cap) begin
                    r.status = ST_FULL;
                end else begin
                    i = heap_fill;
                    heap_keys[i] = w.key_value;
                    heap_fill++;
                    while (i != 0) begin
                        p = (i - 1) / 2;
                        if (!(heap_keys[i] < heap_keys[p])) break;
                        tmp = heap_keys[i];
                        heap_keys[i] = heap_keys[p];
                        heap_keys[p] = tmp;
                        i = p;
                    end
                end
            end
            REQ_EXTRACT: begin
                if (heap_fill == 0) begin
                    r.result_key = INT_MAX;
                    r.status = ST_EMPTY;
                end else begin
                    r.result_key = pop_min_key();
                end
            end
            REQ_DELETE: begin
                if (w.entry_index >= heap_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    // The chosen entry climbs to the root regardless of the keys on its path.
                    i = w.entry_index;
                    while (i != 0) begin
                        p = (i - 1) / 2;
                        tmp = heap_keys[i];
                        heap_keys[i] = heap_keys[p];
                        heap_keys[p] = tmp;
                        i = p;
                    end
                    void'(pop_min_key());
                end
            end
            default: begin
            end
        endcase
        r.occupancy = heap_fill[CAP_W-1:0];
        return r;
    endfunction

    function automatic t_in_word make_word(t_req req, logic signed [31:0] key, logic [5:0] idx);
        t_in_word w;
        w.req_type = req;
        w.key_value = key;
        w.entry_index = idx;
        return w;
    endfunction

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return INT_MAX;
            2, 3, 4: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_in_word pick_request();
        t_in_word w;
        int       pick;
        int       insert_share;
        w.key_value = pick_key();
        w.entry_index = 6'($urandom_range(0, 63));
        insert_share = (heap_fill < 24) ? 60 : 45;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            w.req_type = REQ_IGNORE;
        end else if (pick < insert_share) begin
            w.req_type = REQ_INSERT;
        end else if (pick < 80) begin
            w.req_type = REQ_EXTRACT;
        end else begin
            w.req_type = REQ_DELETE;
            if (heap_fill > 0 && pick < 96) w.entry_index = 6'($urandom_range(0, heap_fill - 1));
        end
        return w;
    endfunction

    // Presents one request word and records its expected result once it is taken.
    // Valid is left high on return; the next call or finish_phase decides its next value.
    task automatic send_word(t_in_word w);
        int gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_words.push_back(predict_heap_result(w));
    endtask

    task automatic finish_phase();
        int waited = 0;
        in_valid <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        heap_cap = value;
    endtask

    task automatic note_mismatch(string what, t_out_word want, t_out_word got);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT) begin
            $display("mismatch %0d (%s): expected key=%0d status=%0d occ=%0d, got key=%0d status=%0d occ=%0d",
                     mismatch_count, what, want.result_key, want.status, want.occupancy,
                     got.result_key, got.status, got.occupancy);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                note_mismatch("result word with no request pending", '0, o_out_word);
            end else begin
                oldest_word = pending_words.pop_front();
                if (o_out_word.result_key !== oldest_word.result_key ||
                    o_out_word.status !== oldest_word.status ||
                    o_out_word.occupancy !== oldest_word.occupancy) begin
                    note_mismatch("result word", oldest_word, o_out_word);
                end
            end
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd0));
        send_word(make_word(REQ_IGNORE, 32'sd0, 6'd0));
        send_word(make_word(REQ_INSERT, INT_MAX, 6'd0));
        send_word(make_word(REQ_INSERT, 32'sh8000_0000, 6'd63));
        send_word(make_word(REQ_INSERT, 32'sd0, 6'd0));
        send_word(make_word(REQ_INSERT, -32'sd1, 6'd0));
        send_word(make_word(REQ_INSERT, 32'sd1, 6'd0));
        send_word(make_word(REQ_INSERT, 32'sd0, 6'd0));
        send_word(make_word(REQ_INSERT, -32'sd1, 6'd0));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd63));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd6));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd3));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd0));
        send_word(make_word(REQ_IGNORE, -32'sd1, 6'd63));
        repeat (4) send_word(make_word(REQ_EXTRACT, -32'sd1, 6'd63));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        finish_phase();
    endtask

    task automatic test_capacity_limits();
        send_idle_pct = 13;
        recv_stall_pct = 13;
        set_capacity(7'd1);
        send_word(make_word(REQ_INSERT, 32'sd5, 6'd0));
        send_word(make_word(REQ_INSERT, 32'sd6, 6'd0));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        finish_phase();
        // A zero capacity refuses every insert.
        set_capacity(7'd0);
        send_word(make_word(REQ_INSERT, 32'sd7, 6'd0));
        send_word(make_word(REQ_DELETE, 32'sd0, 6'd0));
        finish_phase();
        set_capacity(7'd64);
        repeat (5) send_word(make_word(REQ_INSERT, pick_key(), 6'd0));
        finish_phase();
        // Lowering the capacity below the fill keeps the entries but blocks inserts.
        set_capacity(7'd3);
        send_word(make_word(REQ_INSERT, 32'sd9, 6'd0));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        send_word(make_word(REQ_INSERT, 32'sd9, 6'd0));
        send_word(make_word(REQ_EXTRACT, 32'sd0, 6'd0));
        send_word(make_word(REQ_INSERT, -32'sd9, 6'd0));
        finish_phase();
    endtask

    task automatic test_full_heap();
        send_idle_pct = 13;
        recv_stall_pct = 13;
        // Anything above the array depth acts as the depth itself.
        set_capacity(7'd127);
        while (heap_fill < DEPTH) send_word(make_word(REQ_INSERT, pick_key(), 6'($urandom)));
        repeat (3) send_word(make_word(REQ_INSERT, pick_key(), 6'd0));
        send_word(make_word(REQ_DELETE, pick_key(), 6'd63));
        send_word(make_word(REQ_DELETE, pick_key(), 6'd0));
        repeat (5) send_word(make_word(REQ_DELETE, pick_key(), 6'($urandom_range(0, heap_fill - 1))));
        while (heap_fill > 0) send_word(make_word(REQ_EXTRACT, pick_key(), 6'($urandom)));
        send_word(make_word(REQ_EXTRACT, pick_key(), 6'($urandom)));
        finish_phase();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, logic [CAP_W-1:0] cap, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        set_capacity(cap);
        repeat (count) send_word(pick_request());
        finish_phase();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity_limits();
        test_full_heap();
        test_random_traffic(0, 0, 7'd64, 170);
        test_random_traffic(50, 0, 7'd127, 170);
        test_random_traffic(0, 50, 7'd9, 150);
        test_random_traffic(13, 13, 7'd40, 150);
        while (pending_words.size() != 0) begin
            oldest_word = pending_words.pop_front();
            note_mismatch("result word never arrived", oldest_word, '0);
        end
        if (mismatch_count == 0) begin
            $display("** binary_min_heap_queue_top: PASSED **");
        end else begin
            $display("** binary_min_heap_queue_top: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_ram.sv
rtl/core/binary_min_heap_queue_top.sv
tb/sv/tb_binary_min_heap_queue_top.sv
